/* hdl/alternating_run_length_bit_decoder_macros.svh */
// Assertion macros for the alternating run-length bit decoder.
// Included by the top level. The including module must have i_clk and i_rst_n.
`ifndef ALTERNATING_RUN_LENGTH_BIT_DECODER_MACROS_SVH
`define ALTERNATING_RUN_LENGTH_BIT_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ALRD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ALRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/alrd_pkg.sv */
// Shared types and constants of the alternating run-length bit decoder.
// No dependencies; used by alrd_unpack, alrd_fifo and the top level.
`default_nettype none

package alrd_pkg;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam int BYTE_BITS = 8;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

    // One decoded result.
    typedef struct packed {
        logic [7:0] data_byte;
        logic [3:0] valid_bits;
        logic       last;
    } t_result;

    // Decoder state carried from one item to the next.
    typedef struct packed {
        logic       level;
        logic [6:0] pend_bits;
        logic [2:0] pend_cnt;
    } t_state;

    // What one item produces: up to two results and the next state.
    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
        t_state     nxt;
    } t_unpack;

    localparam t_state STATE_RESET = '{level: 1'b0, pend_bits: 7'd0, pend_cnt: 3'd0};

endpackage

`default_nettype wire

/* hdl/alrd_unpack.sv */
// Combinational unpacker: one run character plus the current state gives
// up to two output bytes and the next state. Depends on alrd_pkg.
`default_nettype none

module alrd_unpack
    import alrd_pkg::*;
(
    input  wire logic [7:0] i_run_char,
    input  wire logic       i_eom,
    input  wire t_state     i_state,
    output t_unpack         o_unpack
);

    logic [3:0]  run_len;
    logic [4:0]  total;
    logic [15:0] ones;
    logic [15:0] merged;
    logic [15:0] shifted;
    logic [1:0]  n_full;
    logic [2:0]  rem_cnt;
    logic [6:0]  rem_mask;
    logic [6:0]  rem_bits;
    t_result     full_a;
    t_result     full_b;
    t_result     tail;

    always_comb begin
        if (i_run_char >= CHAR_ZERO && i_run_char <= CHAR_NINE) begin
            run_len = 4'(i_run_char - CHAR_ZERO);
        end else begin
            run_len = 4'd0;
        end

        // Old bits move up, the new run fills the low end.
        ones   = (16'd1 << run_len) - 16'd1;
        merged = ({9'd0, i_state.pend_bits} << run_len) | (i_state.level ? ones : 16'd0);
        total  = {2'b00, i_state.pend_cnt} + {1'b0, run_len};

        full_a  = '{data_byte: 8'd0, valid_bits: 4'(BYTE_BITS), last: 1'b0};
        full_b  = '{data_byte: 8'd0, valid_bits: 4'(BYTE_BITS), last: 1'b0};
        shifted = merged >> total[2:0];
        if (total[4]) begin
            // Exactly sixteen bits: two full bytes and nothing left over.
            n_full           = 2'd2;
            full_a.data_byte = merged[15:8];
            full_b.data_byte = merged[7:0];
            rem_cnt          = 3'd0;
        end else if (total[3]) begin
            n_full           = 2'd1;
            full_a.data_byte = shifted[7:0];
            rem_cnt          = total[2:0];
        end else begin
            n_full  = 2'd0;
            rem_cnt = total[2:0];
        end

        rem_mask = 7'((8'd1 << rem_cnt) - 8'd1);
        rem_bits = merged[6:0] & rem_mask;

        tail = '{data_byte: {1'b0, rem_bits}, valid_bits: {1'b0, rem_cnt}, last: 1'b1};

        o_unpack.num  = n_full;
        o_unpack.res0 = full_a;
        o_unpack.res1 = full_b;
        o_unpack.nxt  = '{level: ~i_state.level, pend_bits: rem_bits, pend_cnt: rem_cnt};

        if (i_eom) begin
            o_unpack.nxt = STATE_RESET;
            if (rem_cnt != 3'd0) begin
                // Partial byte goes out right-aligned after any full byte.
                if (n_full == 2'd0) begin
                    o_unpack.res0 = tail;
                    o_unpack.num  = 2'd1;
                end else begin
                    o_unpack.res1 = tail;
                    o_unpack.num  = 2'd2;
                end
            end else if (n_full == 2'd2) begin
                o_unpack.res1.last = 1'b1;
            end else if (n_full == 2'd1) begin
                o_unpack.res0.last = 1'b1;
            end else begin
                // Nothing to give: send the empty marker.
                o_unpack.res0 = '{data_byte: 8'd0, valid_bits: 4'd0, last: 1'b1};
                o_unpack.num  = 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/alrd_fifo.sv */
// Small result queue that takes up to two results per cycle and gives one.
// Depends on alrd_pkg.
`default_nettype none

module alrd_fifo
    import alrd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [1:0]         i_wr_num,
    input  wire t_result            i_wr_a,
    input  wire t_result            i_wr_b,
    input  wire logic               i_pop,
    output t_result                 o_head,
    output logic [FIFO_CW-1:0]      o_count
);

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_CW-1:0]   r_count;
    logic [FIFO_AW-1:0]   n_wr_ptr;
    logic [FIFO_AW-1:0]   n_rd_ptr;
    logic [FIFO_CW-1:0]   n_count;
    logic [FIFO_AW-1:0]   wr_ptr_b;

    assign wr_ptr_b = r_wr_ptr + FIFO_AW'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_AW'(i_wr_num);
        n_rd_ptr = r_rd_ptr + (i_pop ? FIFO_AW'(1) : FIFO_AW'(0));
        n_count  = r_count + FIFO_CW'(i_wr_num) - (i_pop ? FIFO_CW'(1) : FIFO_CW'(0));
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_wr_a;
        end
        if (i_wr_num == 2'd2) begin
            r_mem[wr_ptr_b] <= i_wr_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

`default_nettype wire

/* hdl/alternating_run_length_bit_decoder.sv */
// Top level of the alternating run-length bit decoder.
// Depends on alrd_pkg, alrd_unpack, alrd_fifo and the assertion macro header.
//
//  Channel   Direction  tdata (low bit up)                    tlast
//  s_axis    in         run_char[7:0]                         end_of_message
//  m_axis    out        data_byte[7:0], valid_bits[11:8], 0s  last
//
// An item waits in the holding register until its results are written to the queue.
// One item is taken per cycle while the queue has room; each item yields at most two
// results, which leave the four-entry queue one per cycle while the sink is ready.
// The input holding register drains whenever the queue has room for two results.
// Reset is synchronous and active low; it clears the run state and the queue.
// A stalled output only blocks the input once the queue is nearly full.
`default_nettype none

`include "alternating_run_length_bit_decoder_macros.svh"

module alternating_run_length_bit_decoder
    import alrd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] run_char
    input  wire logic        i_s_tlast,   // end_of_message
    // Output stream.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // [7:0] data_byte, [11:8] valid_bits, rest 0
    output logic             o_m_tlast    // last
);

    // Input holding register: one item waits here for the unpacker.
    logic                r_in_valid;
    logic [7:0]          r_in_char;
    logic                r_in_eom;
    // Run level and pending partial byte.
    t_state              r_state;

    logic                in_xfer;
    logic                fire;
    logic                pop;
    t_unpack             unpack;
    t_result             head;
    logic [FIFO_CW-1:0]  fifo_count;

    // The unpacker result is written into the queue only when two slots are free,
    // so the worst case of two results per item always fits.
    assign fire       = r_in_valid && (fifo_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign o_s_tready = !r_in_valid || fire;
    assign in_xfer    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= STATE_RESET;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_state <= unpack.nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_char <= i_s_tdata;
            r_in_eom  <= i_s_tlast;
        end
    end

    alrd_unpack u_unpack (
        .i_run_char (r_in_char),
        .i_eom      (r_in_eom),
        .i_state    (r_state),
        .o_unpack   (unpack)
    );

    alrd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_num (fire ? unpack.num : 2'd0),
        .i_wr_a   (unpack.res0),
        .i_wr_b   (unpack.res1),
        .i_pop    (pop),
        .o_head   (head),
        .o_count  (fifo_count)
    );

    assign o_m_tvalid = (fifo_count != '0);
    assign pop        = o_m_tvalid && i_m_tready;
    assign o_m_tdata  = {4'd0, head.valid_bits, head.data_byte};
    assign o_m_tlast  = head.last;

    // The queue never overflows.
    `ALRD_ASSERT_SAME(a_fifo_bound, 1'b1, fifo_count <= FIFO_CW'(FIFO_DEPTH), "result queue overflow")
    // Ending a message puts the run state back to its reset value.
    `ALRD_ASSERT_NEXT(a_eom_reset, fire && r_in_eom, r_state == STATE_RESET, "state not reset after end of message")
    // Bits above the pending count are always clear.
    `ALRD_ASSERT_SAME(a_pend_clean, 1'b1, (r_state.pend_bits >> r_state.pend_cnt) == 7'd0, "stray pending bits")
    // A partial byte or an empty marker always closes the message.
    `ALRD_ASSERT_SAME(a_partial_last, o_m_tvalid && head.valid_bits != 4'(BYTE_BITS), head.last && head.valid_bits < 4'(BYTE_BITS), "short result without last")

endmodule

`default_nettype wire

/* sim/alternating_run_length_bit_decoder_tb.sv */
// Self-checking testbench for the alternating run-length bit decoder.
// Depends on alrd_pkg and the alternating_run_length_bit_decoder top level; a bit-level
// predictor builds the expected result stream, which is compared with every output transfer.
`default_nettype none

module alternating_run_length_bit_decoder_tb
    import alrd_pkg::*;
();

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    // Percent chance of an idle cycle on the input side and of a stall on the output side.
    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned fail_count = 0;

    // Bit-stream state of the predictor.
    logic        run_level = 1'b0;
    logic [6:0]  pend_bits = 7'd0;
    logic [2:0]  pend_cnt = 3'd0;
    t_result     expected_bytes[$];

    alternating_run_length_bit_decoder u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    // Expands one accepted run character into bits and queues the bytes it completes.
    task automatic predict_run(input logic [7:0] ch, input logic eom);
        logic [7:0]  acc;
        int unsigned cnt;
        int unsigned run_len;
        int unsigned i;
        int unsigned produced;
        t_result     fresh[2];
        acc = {1'b0, pend_bits};
        cnt = pend_cnt;
        run_len = 0;
        produced = 0;
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            run_len = ch - CHAR_ZERO;
        end
        for (i = 0; i < run_len; i++) begin
            acc = {acc[6:0], run_level};
            cnt++;
            if (cnt == BYTE_BITS) begin
                fresh[produced] = '{data_byte: acc, valid_bits: 4'd8, last: 1'b0};
                produced++;
                acc = 8'd0;
                cnt = 0;
            end
        end
        run_level = ~run_level;
        pend_bits = acc[6:0];
        pend_cnt = cnt[2:0];
        if (eom) begin
            if (pend_cnt != 3'd0) begin
                // Leftover bits leave right-aligned as the closing partial byte.
                fresh[produced] = '{data_byte: {1'b0, pend_bits},
                                    valid_bits: {1'b0, pend_cnt}, last: 1'b1};
                produced++;
            end else if (produced > 0) begin
                fresh[produced - 1].last = 1'b1;
            end else begin
                // Nothing to flush: an empty marker closes the message.
                fresh[0] = '{data_byte: 8'd0, valid_bits: 4'd0, last: 1'b1};
                produced = 1;
            end
            run_level = 1'b0;
            pend_bits = 7'd0;
            pend_cnt = 3'd0;
        end
        for (i = 0; i < produced; i++) begin
            expected_bytes.push_back(fresh[i]);
        end
    endtask

    // Presents one item, with random idle cycles ahead of it, and waits for its transfer.
    task automatic send_run(input logic [7:0] ch, input logic eom);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= ch;
        s_tlast <= eom;
        @(posedge clk);
        while (!s_tready) begin
            @(posedge clk);
        end
        predict_run(ch, eom);
    endtask

    // Stops sending and waits until every predicted byte has left the block.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_bytes.size() != 0) begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    always @(posedge clk) begin
        m_tready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk) begin
        t_result want;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_bytes.size() == 0) begin
                $error("result transfer with nothing expected: tdata %h tlast %b",
                       m_tdata, m_tlast);
                fail_count++;
            end else begin
                want = expected_bytes.pop_front();
                if (m_tdata[7:0] !== want.data_byte) begin
                    $error("data_byte: expected %h, actual %h", want.data_byte, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tdata[11:8] !== want.valid_bits) begin
                    $error("valid_bits: expected %0d, actual %0d",
                           want.valid_bits, m_tdata[11:8]);
                    fail_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %b, actual %b", want.last, m_tlast);
                    fail_count++;
                end
                if (m_tdata[15:12] !== 4'd0) begin
                    $error("tdata padding: expected 0, actual %h", m_tdata[15:12]);
                    fail_count++;
                end
            end
        end
    end

    // Longest runs, zero runs, a run that completes two bytes at once, and the empty marker.
    task automatic test_digit_extremes();
        send_run("9", 1'b1);
        send_run("0", 1'b1);
        send_run("7", 1'b0);
        send_run("9", 1'b1);
    endtask

    // Message ends that land on a byte boundary, mid-byte, and after a full byte.
    task automatic test_end_of_message_cases();
        send_run("8", 1'b1);
        send_run("3", 1'b0);
        send_run("5", 1'b1);
        send_run("1", 1'b0);
        send_run("2", 1'b0);
        send_run("3", 1'b1);
        send_run("5", 1'b0);
        send_run("9", 1'b1);
        send_run("6", 1'b0);
        send_run("2", 1'b1);
    endtask

    // Bytes outside the digit range add no bits but still flip the level.
    task automatic test_non_digit_bytes();
        send_run(8'h00, 1'b0);
        send_run(8'hFF, 1'b0);
        send_run(CHAR_ZERO - 8'd1, 1'b0);
        send_run(CHAR_NINE + 8'd1, 1'b0);
        send_run("4", 1'b0);
        send_run("4", 1'b1);
        send_run(8'h41, 1'b1);
        send_run("3", 1'b0);
        send_run(8'hFF, 1'b1);
    endtask

    // Random messages, mostly digit runs, with stray bytes and occasional full drains.
    task automatic test_random_messages(input int unsigned n_items);
        int unsigned sent;
        int unsigned msg_len;
        int unsigned k;
        logic [7:0]  ch;
        sent = 0;
        while (sent < n_items) begin
            msg_len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 14);
            for (k = 0; k < msg_len; k++) begin
                if ($urandom_range(99) < 85) begin
                    ch = CHAR_ZERO + 8'($urandom_range(9));
                end else begin
                    ch = 8'($urandom_range(255));
                end
                send_run(ch, k == msg_len - 1);
                sent++;
            end
            if ($urandom_range(24) == 0) begin
                wait_drained();
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_digit_extremes();
        test_end_of_message_cases();
        test_non_digit_bytes();
        wait_drained();

        src_idle_pct = 0;
        sink_stall_pct = 0;
        test_random_messages(275);
        src_idle_pct = 47;
        sink_stall_pct = 0;
        test_random_messages(275);
        src_idle_pct = 0;
        sink_stall_pct = 47;
        test_random_messages(275);
        src_idle_pct = 29;
        sink_stall_pct = 29;
        test_random_messages(275);

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
